>>> rtl/kpd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kpd_pkg
// Types, widths and constants shared by the keyed pair distance block.
// ----------------------------------------------------------------------------
package kpd_pkg;

  localparam int SNAP_BITS     = 16;
  localparam int ID_BITS       = 10;
  localparam int COORD_BITS    = 24;
  localparam int KEY_BITS      = 8;
  localparam int DIST_BITS     = 26;
  localparam int KEY_SLOTS_DEF = 256;
  localparam int QUEUE_DEPTH   = 2;

  // magnitude of a per-axis difference, root and radicand widths
  localparam int ABS_BITS  = COORD_BITS + 1;
  localparam int ROOT_BITS = ABS_BITS + 1;
  localparam int SUM_BITS  = 2 * ROOT_BITS;

  localparam logic [DIST_BITS-1:0] DIST_MAX = '1;
  localparam logic [63:0]          DIST_LIM = 64'd1 << DIST_BITS;

  typedef struct packed {
    logic                         frame_start;
    logic [SNAP_BITS-1:0]         snapshot;
    logic [ID_BITS-1:0]           atom_id;
    logic signed [COORD_BITS-1:0] pos_x;
    logic signed [COORD_BITS-1:0] pos_y;
    logic signed [COORD_BITS-1:0] pos_z;
    logic [KEY_BITS-1:0]          pair_key;
  } kpd_in_t;

  typedef struct packed {
    logic [SNAP_BITS-1:0] out_snapshot;
    logic [ID_BITS-1:0]   first_id;
    logic [ID_BITS-1:0]   second_id;
    logic [DIST_BITS-1:0] distance;
  } kpd_out_t;

  // one stored atom
  typedef struct packed {
    logic [ID_BITS-1:0]           atom_id;
    logic signed [COORD_BITS-1:0] pos_x;
    logic signed [COORD_BITS-1:0] pos_y;
    logic signed [COORD_BITS-1:0] pos_z;
  } kpd_slot_t;

  // a matched pair handed from the front end to the back end
  typedef struct packed {
    logic [SNAP_BITS-1:0] snapshot;
    kpd_slot_t            first;
    kpd_slot_t            second;
  } kpd_pair_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_ROOT,
    ST_DONE
  } kpd_state_t;

endpackage
`default_nettype wire

>>> rtl/kpd_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kpd_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module kpd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]              rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // read data holds until the next read
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

>>> rtl/kpd_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kpd_fifo
// Short register queue carrying matched pairs from front end to back end.
// ----------------------------------------------------------------------------
module kpd_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             wr,
  input  wire logic [WIDTH-1:0] wdata,
  output logic                  full,
  input  wire logic             rd,
  output logic [WIDTH-1:0]      rdata,
  output logic                  empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wptr;
  logic [PW-1:0]    rptr;
  logic [CW-1:0]    count;
  logic             do_wr;
  logic             do_rd;

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign do_wr = wr && !full;
  assign do_rd = rd && !empty;
  assign rdata = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_wr) begin
        wptr <= (wptr == PW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_rd) begin
        rptr <= (rptr == PW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wptr] <= wdata;
    end
  end

endmodule
`default_nettype wire

>>> rtl/kpd_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kpd_front
// Accepts atoms, keeps the pending table and issues matched pairs.
// ----------------------------------------------------------------------------
module kpd_front
  import kpd_pkg::*;
#(
  parameter int KEY_SLOTS = KEY_SLOTS_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire kpd_in_t   atom,
  input  wire logic      push,
  output logic           full,
  output logic           q_push,
  output kpd_pair_t      q_data,
  input  wire logic      q_full
);

  localparam int KW = $clog2(KEY_SLOTS);

  logic [KEY_SLOTS-1:0] valid;
  logic [KEY_SLOTS-1:0] valid_next;
  logic                 pend;
  logic                 pend_next;
  logic [SNAP_BITS-1:0] pend_snap;
  kpd_slot_t            pend_atom;
  kpd_slot_t            new_atom;
  kpd_slot_t            old_atom;
  logic [KW-1:0]        idx;
  logic                 in_range;
  logic                 hit;
  logic                 accept;

  assign idx      = KW'(atom.pair_key);
  assign in_range = (32'(atom.pair_key) < KEY_SLOTS);
  assign hit      = in_range && !atom.frame_start && valid[idx];
  assign full     = pend && q_full;
  assign accept   = push && !full;

  assign new_atom.atom_id = atom.atom_id;
  assign new_atom.pos_x   = atom.pos_x;
  assign new_atom.pos_y   = atom.pos_y;
  assign new_atom.pos_z   = atom.pos_z;

  kpd_ram #(
    .WIDTH ($bits(kpd_slot_t)),
    .DEPTH (KEY_SLOTS)
  ) u_slots (
    .clk   (clk),
    .we    (accept && in_range && !hit),
    .waddr (idx),
    .wdata (new_atom),
    .re    (accept && hit),
    .raddr (idx),
    .rdata (old_atom)
  );

  // frame start wipes the table before the atom itself is handled
  always_comb begin
    valid_next = valid;
    if (accept) begin
      if (atom.frame_start) begin
        valid_next = '0;
      end
      if (in_range) begin
        valid_next[idx] = !hit;
      end
    end
  end

  always_comb begin
    pend_next = pend;
    if (pend && !q_full) begin
      pend_next = 1'b0;
    end
    if (accept && hit) begin
      pend_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      pend  <= 1'b0;
    end else begin
      valid <= valid_next;
      pend  <= pend_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && hit) begin
      pend_snap <= atom.snapshot;
      pend_atom <= new_atom;
    end
  end

  assign q_push          = pend;
  assign q_data.snapshot = pend_snap;
  assign q_data.first    = old_atom;
  assign q_data.second   = pend_atom;

endmodule
`default_nettype wire

>>> rtl/kpd_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kpd_back
// Works out the distance of each matched pair and holds the result beat.
// ----------------------------------------------------------------------------
module kpd_back
  import kpd_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire kpd_pair_t q_data,
  input  wire logic      q_empty,
  output logic           q_pop,
  output kpd_out_t       result,
  output logic           empty,
  input  wire logic      pop
);

  localparam int CNT_W = $clog2(ROOT_BITS);

  kpd_state_t           state;
  kpd_state_t           state_next;
  logic                 load_res;
  logic                 res_valid;
  logic [CNT_W-1:0]     cnt;
  logic [ABS_BITS-1:0]  ax;
  logic [ABS_BITS-1:0]  ay;
  logic [ABS_BITS-1:0]  az;
  logic [ABS_BITS-1:0]  ax_c;
  logic [ABS_BITS-1:0]  ay_c;
  logic [ABS_BITS-1:0]  az_c;
  logic [ABS_BITS-1:0]  sq_in;
  logic [2*ABS_BITS-1:0] prod;
  logic                 ovf;
  logic [SUM_BITS-1:0]  rad;
  logic [ROOT_BITS:0]   rem;
  logic [ROOT_BITS-1:0] root;
  logic [ROOT_BITS+2:0] rem_s;
  logic [ROOT_BITS+2:0] trial;
  logic [ROOT_BITS+2:0] rem_w;
  logic                 ge;
  logic [SNAP_BITS-1:0] snap;
  logic [ID_BITS-1:0]   id_a;
  logic [ID_BITS-1:0]   id_b;
  logic [DIST_BITS-1:0] dist_sat;

  function automatic logic [ABS_BITS-1:0] abs_diff(
    input logic signed [COORD_BITS-1:0] a,
    input logic signed [COORD_BITS-1:0] b
  );
    logic signed [COORD_BITS:0] d;
    d = $signed({a[COORD_BITS-1], a}) - $signed({b[COORD_BITS-1], b});
    return d[COORD_BITS] ? ABS_BITS'(-d) : ABS_BITS'(d);
  endfunction

  assign ax_c = abs_diff(q_data.second.pos_x, q_data.first.pos_x);
  assign ay_c = abs_diff(q_data.second.pos_y, q_data.first.pos_y);
  assign az_c = abs_diff(q_data.second.pos_z, q_data.first.pos_z);

  // one shared squarer, one axis per cycle
  always_comb begin
    case (cnt)
      CNT_W'(0): sq_in = ax;
      CNT_W'(1): sq_in = ay;
      default:   sq_in = az;
    endcase
  end
  assign prod = sq_in * sq_in;

  // one root bit per cycle, two radicand bits consumed
  assign rem_s = {rem, rad[SUM_BITS-1 -: 2]};
  assign trial = {1'b0, root, 2'b01};
  assign ge    = (rem_s >= trial);
  assign rem_w = ge ? (rem_s - trial) : rem_s;

  assign dist_sat = (ovf || (64'(root) > 64'(DIST_MAX))) ? DIST_MAX : DIST_BITS'(root);

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    load_res   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (!q_empty) begin
          q_pop      = 1'b1;
          state_next = ST_SQUARE;
        end
      end
      ST_SQUARE: begin
        if (cnt == CNT_W'(2)) begin
          state_next = ST_ROOT;
        end
      end
      ST_ROOT: begin
        if (cnt == '0) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!res_valid || pop) begin
          load_res   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_res) begin
        res_valid <= 1'b1;
      end else if (pop) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        snap <= q_data.snapshot;
        id_a <= q_data.first.atom_id;
        id_b <= q_data.second.atom_id;
        ax   <= ax_c;
        ay   <= ay_c;
        az   <= az_c;
        ovf  <= (64'(ax_c) >= DIST_LIM) || (64'(ay_c) >= DIST_LIM) ||
                (64'(az_c) >= DIST_LIM);
        rad  <= '0;
        cnt  <= '0;
      end
      ST_SQUARE: begin
        rad <= rad + SUM_BITS'(prod);
        if (cnt == CNT_W'(2)) begin
          rem  <= '0;
          root <= '0;
          cnt  <= CNT_W'(ROOT_BITS - 1);
        end else begin
          cnt <= cnt + 1'b1;
        end
      end
      ST_ROOT: begin
        rem  <= rem_w[ROOT_BITS:0];
        root <= {root[ROOT_BITS-2:0], ge};
        rad  <= {rad[SUM_BITS-3:0], 2'b00};
        cnt  <= cnt - 1'b1;
      end
      default: begin
        if (load_res) begin
          result.out_snapshot <= snap;
          result.first_id     <= id_a;
          result.second_id    <= id_b;
          result.distance     <= dist_sat;
        end
      end
    endcase
  end

  assign empty = !res_valid;

endmodule
`default_nettype wire

>>> rtl/keyed_pair_distance_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// keyed_pair_distance_top
// Pairs atoms by key and reports the distance between the two atoms of a pair.
// ----------------------------------------------------------------------------
// An atom whose key slot is empty is stored; no result follows. An atom that
// finds its partner waits in the front end's holding stage until the queue
// takes the pair. The back end forms the axis differences, runs each axis in
// turn through the shared squarer, works out one root bit per step in the
// square-root loop and hands over the result once the output beat is free.
// That loop sets the sustained pair rate. A queue of QUEUE_DEPTH pairs lets
// atoms keep arriving while a distance is worked out; full rises only when
// that queue and the front end's holding stage are both taken. The
// pending-slot flags sit in flip-flops, so reset and frame start clear the
// table at once and no clearing pass is needed.
module keyed_pair_distance_top
  import kpd_pkg::*;
#(
  parameter int KEY_SLOTS = KEY_SLOTS_DEF
) (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire kpd_in_t atom,
  input  wire logic    push,
  output logic         full,
  output kpd_out_t     result,
  output logic         empty,
  input  wire logic    pop
);

  logic      q_push;
  logic      q_full;
  logic      q_pop;
  logic      q_empty;
  kpd_pair_t q_wdata;
  kpd_pair_t q_rdata;

  kpd_front #(
    .KEY_SLOTS (KEY_SLOTS)
  ) u_front (
    .clk    (clk),
    .rst    (rst),
    .atom   (atom),
    .push   (push),
    .full   (full),
    .q_push (q_push),
    .q_data (q_wdata),
    .q_full (q_full)
  );

  kpd_fifo #(
    .WIDTH ($bits(kpd_pair_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .wr    (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .rd    (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  kpd_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_data  (q_rdata),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .result  (result),
    .empty   (empty),
    .pop     (pop)
  );

endmodule
`default_nettype wire

>>> rtl/kpd_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kpd_checker
// Port-level checks on the keyed pair distance block.
// ----------------------------------------------------------------------------
module kpd_checker
  import kpd_pkg::*;
(
  input wire logic     clk,
  input wire logic     rst,
  input wire kpd_in_t  atom,
  input wire logic     push,
  input wire logic     full,
  input wire kpd_out_t result,
  input wire logic     empty,
  input wire logic     pop
);

  // reset leaves nothing waiting and the input open
  a_reset_clear: assert property (@(posedge clk)
    rst |=> empty && !full)
    else $error("result waiting or input blocked after reset");

  // a waiting beat that is not taken stays put
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty && $stable(result))
    else $error("waiting result changed or vanished");

  // back-pressure only builds after a pair-completing atom was offered
  a_full_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(full) |-> $past(push))
    else $error("full rose without a preceding push");

endmodule

bind keyed_pair_distance_top kpd_checker u_kpd_checker (.*);
`default_nettype wire
